// ===== rtl/core/mrwr_pkg.sv =====
// Package for the Miller-Rabin witness round block.
// Holds widths, verdict codes, FSM states and controller/datapath command and status types.
package mrwr_pkg;
  localparam int W = 31;
  localparam int CW = 5;   // bit counter for W-bit values

  typedef enum logic [1:0] {
    V_COMPOSITE = 2'd0,
    V_PROBABLE  = 2'd1,
    V_SMALL     = 2'd2,
    V_REJECT    = 2'd3
  } verdict_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SPLIT, S_REDUCE, S_MULACC, S_MULSQ, S_TEST, S_SQR,
    S_SQTEST, S_DONE
  } state_t;

  // multiplier operand selects
  typedef enum logic [1:0] {
    M_ACC_SQ, M_SQ_SQ, M_A_ONE, M_ACC_ACC
  } mop_t;

  typedef struct packed {
    logic load;       // capture operands
    logic split_step; // shift r right, count s
    logic mstart;     // start modular multiply
    mop_t mop;
    logic to_acc;     // write product to acc
    logic to_sq;      // write product to sq
    logic shift_e;    // shift exponent
    logic jinc;       // count squaring step
  } cmd_t;

  typedef struct packed {
    logic lt2;
    logic is_small;
    logic r_odd;
    logic mdone;
    logic e_zero;
    logic e_lsb;
    logic acc_one;
    logic acc_nm1;
    logic j_last;     // j + 1 >= s
  } stat_t;
endpackage

// ===== rtl/core/mrwr_mulmod.sv =====
// Iterative modular multiplier: (x*y) mod m, one multiplier bit per cycle.
// Depends on mrwr_pkg.
module mrwr_mulmod import mrwr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic [W-1:0] p,
  output logic         done
);
  logic [W-1:0] acc, xr, yr, mr;
  logic [CW:0]  cnt;
  logic         busy;
  logic [W:0]   dbl, dbl_r, add, add_r;

  // shift-add from MSB of y, reducing after each doubling and each add
  always_comb begin
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, mr}) ? dbl - {1'b0, mr} : dbl;
    add   = dbl_r + (yr[W-1] ? {1'b0, xr} : '0);
    add_r = (add >= {1'b0, mr}) ? add - {1'b0, mr} : add;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      acc  <= '0;
      // x must be below m; reduce once via loop invariant (x < m assumed)
      xr   <= x;
      yr   <= y;
      mr   <= m;
    end else if (busy) begin
      acc <= add_r[W-1:0];
      yr  <= {yr[W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
      if (cnt == (CW+1)'(W-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
  // product is valid in acc while done is high
  assign p = acc;
endmodule

// ===== rtl/core/mrwr_datapath.sv =====
// Datapath: operand registers, exponent split, modular multiplier and compares.
// Depends on mrwr_pkg, mrwr_mulmod and mrwr_sqfix.
module mrwr_datapath import mrwr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [W-1:0] candidate,
  input  logic [W-1:0] witness,
  input  cmd_t         cmd,
  output stat_t        st
);
  logic [W-1:0] n, e, acc, sq, nm1, mx, my, prod;
  logic [CW-1:0] s, j;
  logic mdone_r;
  logic [W-1:0] pq;
  logic pdone;
  logic ez;

  assign nm1 = n - 1'b1;

  // operand select
  always_comb begin
    case (cmd.mop)
      M_ACC_SQ:  begin mx = acc; my = sq; end
      M_SQ_SQ:   begin mx = sq;  my = sq; end
      M_A_ONE:   begin mx = sq;  my = W'(1); end
      M_ACC_ACC: begin mx = acc; my = acc; end
      default:   begin mx = acc; my = sq; end
    endcase
  end

  // raw witness may exceed n: reduce by multiplying with 1 is exact only if
  // x < m, so the multiplier sees y=witness, x=1 for the reduction case
  mrwr_mulmod u_mm (
    .clk(clk), .rst(rst), .start(cmd.mstart),
    .x(cmd.mop == M_A_ONE ? W'(1) : mx),
    .y(cmd.mop == M_A_ONE ? sq : my),
    .m(n), .p(pq), .done(pdone)
  );
  assign prod = pq;

  // exponent exhausted
  mrwr_sqfix u_ez (.a(e), .z(ez));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n   <= candidate;
      sq  <= witness;
      e   <= candidate - 1'b1;
      s   <= '0;
      j   <= '0;
      acc <= W'(1);
    end
    if (cmd.split_step) begin
      e <= e >> 1;
      s <= s + 1'b1;
    end
    if (cmd.shift_e) e <= e >> 1;
    if (pdone && cmd.to_acc) acc <= prod;
    if (pdone && cmd.to_sq)  sq  <= prod;
    if (cmd.jinc) j <= j + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) mdone_r <= 1'b0;
    else     mdone_r <= pdone;
  end

  always_comb begin
    st.lt2      = (n < W'(2));
    st.is_small = (n == W'(2)) || (n == W'(3));
    st.r_odd    = e[0];
    st.mdone    = mdone_r;
    st.e_zero   = ez;
    st.e_lsb    = e[0];
    st.acc_one  = (acc == W'(1));
    st.acc_nm1  = (acc == nm1);
    st.j_last   = ((CW+1)'(j) + 1'b1 >= (CW+1)'(s));
  end
endmodule

// ===== rtl/core/mrwr_ctrl.sv =====
// Controller FSM sequencing one witness round over the datapath.
// Depends on mrwr_pkg.
module mrwr_ctrl import mrwr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output verdict_t verdict,
  input  stat_t    st,
  output cmd_t     cmd
);
  state_t state, state_next;
  verdict_t vres, vres_next;
  logic wait_m, wait_m_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; wait_m <= 1'b0; vres <= V_COMPOSITE;
    end else begin
      state <= state_next; wait_m <= wait_m_next; vres <= vres_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign verdict   = vres;

  // next state and commands; wait_m marks a multiply in flight
  always_comb begin
    state_next  = state;
    vres_next   = vres;
    wait_m_next = wait_m;
    cmd = '0;
    cmd.mop = M_ACC_SQ;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.lt2) begin vres_next = V_REJECT; state_next = S_DONE; end
        else if (st.is_small) begin vres_next = V_SMALL; state_next = S_DONE; end
        else state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if (st.r_odd) state_next = S_REDUCE;
        else cmd.split_step = 1'b1;
      end
      S_REDUCE: begin
        cmd.mop = M_A_ONE; cmd.to_sq = 1'b1;
        if (!wait_m) begin cmd.mstart = 1'b1; wait_m_next = 1'b1; end
        else if (st.mdone) begin wait_m_next = 1'b0; state_next = S_MULACC; end
      end
      S_MULACC: begin
        if (st.e_zero) state_next = S_TEST;
        else if (!st.e_lsb) state_next = S_MULSQ;
        else begin
          cmd.mop = M_ACC_SQ; cmd.to_acc = 1'b1;
          if (!wait_m) begin cmd.mstart = 1'b1; wait_m_next = 1'b1; end
          else if (st.mdone) begin wait_m_next = 1'b0; state_next = S_MULSQ; end
        end
      end
      S_MULSQ: begin
        cmd.mop = M_SQ_SQ; cmd.to_sq = 1'b1;
        if (!wait_m) begin cmd.mstart = 1'b1; wait_m_next = 1'b1; end
        else if (st.mdone) begin
          wait_m_next = 1'b0; cmd.shift_e = 1'b1; state_next = S_MULACC;
        end
      end
      S_TEST: begin
        if (st.acc_one || st.acc_nm1) begin vres_next = V_PROBABLE; state_next = S_DONE; end
        else if (st.j_last) begin vres_next = V_COMPOSITE; state_next = S_DONE; end
        else state_next = S_SQR;
      end
      S_SQR: begin
        // square acc: both operands taken from acc
        cmd.mop = M_ACC_ACC; cmd.to_acc = 1'b1; cmd.to_sq = 1'b1;
        if (!wait_m) begin cmd.mstart = 1'b1; wait_m_next = 1'b1; end
        else if (st.mdone) begin
          wait_m_next = 1'b0; cmd.jinc = 1'b1; state_next = S_SQTEST;
        end
      end
      S_SQTEST: begin
        if (st.acc_nm1) begin vres_next = V_PROBABLE; state_next = S_DONE; end
        else if (st.acc_one) begin vres_next = V_COMPOSITE; state_next = S_DONE; end
        else if (st.j_last) begin vres_next = V_COMPOSITE; state_next = S_DONE; end
        else state_next = S_SQR;
      end
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/core/mrwr_sqfix.sv =====
// Zero detect on a W-bit value; flags the exhausted exponent.
// Depends on mrwr_pkg.
module mrwr_sqfix import mrwr_pkg::*; (
  input  logic [W-1:0] a,
  output logic         z
);
  assign z = (a == '0);
endmodule

// ===== rtl/core/miller_rabin_witness_round.sv =====
// Top level of one Miller-Rabin witness round.
// Depends on mrwr_pkg, mrwr_ctrl, mrwr_datapath.
//
//  channel | signals                          | beat
//  in      | in_valid in_ready candidate witness | one candidate and base
//  out     | out_valid out_ready verdict      | one verdict
//
// One item at a time. Each modular multiply runs through start, W shift-add
// steps, done, and the registered done seen by the FSM. Candidates below 4
// get their verdict straight from the check state, with no multiply.
// Synchronous reset returns the controller to idle.
// A verdict holds until taken; no new item is accepted until then.
module miller_rabin_witness_round import mrwr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [W-1:0]  candidate,
  input  logic [W-1:0]  witness,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    verdict
);
  cmd_t cmd;
  stat_t st;
  verdict_t v;

  mrwr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .verdict(v), .st, .cmd
  );
  mrwr_datapath u_dp (
    .clk, .rst, .candidate, .witness, .cmd, .st
  );
  assign verdict = v;

  // verdict holds while waiting
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("verdict changed while stalled");
  // never ready for input while a verdict is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in_ready with pending verdict");
  // an accepted beat never yields an output in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("verdict too early");
endmodule
